FILE: rtl/core/fde_pkg.sv
// ----------------------------------------------------------------------------
// Forward difference extremum package
// Types, widths and status codes shared by the extremum pipeline.
// ----------------------------------------------------------------------------
package fde_pkg;

	localparam int DATA_W  = 32;
	localparam int STEP_W  = 31;
	localparam int DIFF_W  = 35;
	localparam int A_W     = 37;
	localparam int AMAG_W  = 36;
	localparam int B_W     = 39;
	localparam int BMAG_W  = 38;
	localparam int C_W     = 38;
	localparam int CMAG_W  = 37;
	localparam int DISC_W  = 78;
	localparam int ROOT_W  = DISC_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int NUM_W   = 41;
	localparam int NMAG_W  = NUM_W - 1;
	localparam int N_W     = NMAG_W + STEP_W + 1;
	localparam int DIV_W   = AMAG_W + 1;
	localparam int Q_W     = 41;
	localparam int BB_SPLIT = BMAG_W / 2;
	localparam int AC_SPLIT = AMAG_W / 2;
	localparam int NH_SPLIT = NMAG_W / 2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NEG_DISC = 2'd1,
		ST_ZERO_D3  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x_start;
		logic        [STEP_W-1:0] step;
		logic signed [DATA_W-1:0] sample0;
		logic signed [DATA_W-1:0] sample1;
		logic signed [DATA_W-1:0] sample2;
		logic signed [DATA_W-1:0] sample3;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] point_plus;
		logic                     plus_is_max;
		logic signed [DATA_W-1:0] point_minus;
		logic                     minus_is_max;
		status_t                  status;
	} out_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic        [STEP_W-1:0] h;
		logic signed [B_W-1:0]    b;
		logic                     a_neg;
		logic        [AMAG_W-1:0] a_mag;
		status_t                  status;
		logic                     disc_nz;
	} sq_side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [DISC_W-1:0] bits;
		sq_side_t          side;
	} sq_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [Q_W-1:0]   nq;
		logic             ovf;
		logic             neg;
	} dv_lane_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic        [DIV_W-1:0]  dvs;
		status_t                  status;
		logic                     disc_nz;
	} dv_side_t;

	typedef struct packed {
		dv_lane_t [1:0] lane;
		dv_side_t       side;
	} dv_t;

endpackage

FILE: rtl/core/forward_difference_extremum.sv
// ----------------------------------------------------------------------------
// Forward difference extremum
// Stationary points of the cubic through four equally spaced samples.
//
//   Channel  Handshake            Payload
//   item     item_valid/stall     in_item_t: x_start, step, sample0..3
//   result   result_valid/stall   out_item_t: both points, flags, status
//
// One item enters per cycle while item_stall is low.
// The pipeline holds a square root chain of 39 cells and a
// divider chain of 41 cells, one bit per cell.
// Reset clears all valid flags and empties the two-entry result buffer.
// The pipeline holds while the buffer is full and a new result waits to enter it.
// ----------------------------------------------------------------------------
module forward_difference_extremum import fde_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	localparam logic signed [Q_W+1:0] PT_MAX =
		{{(Q_W+3-DATA_W){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [Q_W+1:0] PT_MIN = ~PT_MAX;

	logic en;
	logic sq_v [ROOT_W+1];
	sq_t  sq_d [ROOT_W+1];
	logic dv_v [Q_W+1];
	dv_t  dv_d [Q_W+1];

	logic signed [NUM_W-1:0]  nb, rt, np, nm;
	logic [NMAG_W-1:0]        mp_s7, mm_s7;
	logic                     gp_s7, gm_s7, v_s7, v_s8, v_s9;
	sq_side_t                 sd_s7;
	logic [NH_SPLIT+STEP_W-1:0]        pl_s8, ml_s8;
	logic [NMAG_W-NH_SPLIT+STEP_W-1:0] ph_s8, mh_s8;
	logic                     gp_s8, gm_s8;
	sq_side_t                 sd_s8;
	logic [N_W-1:0]           np_s9, nm_s9;
	logic                     gp_s9, gm_s9;
	sq_side_t                 sd_s9;
	logic [N_W-1:0]           nsel [2];
	logic                     gsel [2];

	out_item_t res;
	out_item_t buf0_q, buf1_q;
	logic [1:0] cnt_q;
	logic push, pop;

	function automatic logic signed [DATA_W-1:0] place_pt(
		input logic signed [DATA_W-1:0] x,
		input dv_lane_t ln
	);
		logic signed [Q_W+1:0] off;
		logic signed [Q_W+1:0] sum;
		logic [DATA_W-1:0]     r;
		off = signed'((Q_W+2)'(ln.nq));
		if (ln.neg) begin
			off = -off;
		end
		sum = (Q_W+2)'(x) + off;
		if (ln.ovf || (ln.nq[Q_W-1] && (ln.nq[Q_W-2:0] != '0))) begin
			r = ln.neg ? DATA_W'(PT_MIN) : DATA_W'(PT_MAX);
		end else if (sum > PT_MAX) begin
			r = DATA_W'(PT_MAX);
		end else if (sum < PT_MIN) begin
			r = DATA_W'(PT_MIN);
		end else begin
			r = DATA_W'(sum);
		end
		return signed'(r);
	endfunction

	assign en         = (cnt_q != 2'd2) || !dv_v[Q_W];
	assign item_stall = !en;

	fde_coef u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_in (item_valid),
		.item   (item),
		.vld_q  (sq_v[0]),
		.d_q    (sq_d[0])
	);

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		fde_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (sq_v[i]),
			.d_in   (sq_d[i]),
			.vld_q  (sq_v[i+1]),
			.d_q    (sq_d[i+1])
		);
	end

	always_comb begin
		nb = -NUM_W'(sq_d[ROOT_W].side.b);
		rt = signed'(NUM_W'(sq_d[ROOT_W].root));
		np = nb + rt;
		nm = nb - rt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s7 <= sq_v[ROOT_W];
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s7 <= NMAG_W'(np[NUM_W-1] ? -np : np);
			mm_s7 <= NMAG_W'(nm[NUM_W-1] ? -nm : nm);
			gp_s7 <= np[NUM_W-1] ^ sq_d[ROOT_W].side.a_neg;
			gm_s7 <= nm[NUM_W-1] ^ sq_d[ROOT_W].side.a_neg;
			sd_s7 <= sq_d[ROOT_W].side;

			pl_s8 <= (NH_SPLIT+STEP_W)'(mp_s7[NH_SPLIT-1:0])
				* (NH_SPLIT+STEP_W)'(sd_s7.h);
			ph_s8 <= (NMAG_W-NH_SPLIT+STEP_W)'(mp_s7[NMAG_W-1:NH_SPLIT])
				* (NMAG_W-NH_SPLIT+STEP_W)'(sd_s7.h);
			ml_s8 <= (NH_SPLIT+STEP_W)'(mm_s7[NH_SPLIT-1:0])
				* (NH_SPLIT+STEP_W)'(sd_s7.h);
			mh_s8 <= (NMAG_W-NH_SPLIT+STEP_W)'(mm_s7[NMAG_W-1:NH_SPLIT])
				* (NMAG_W-NH_SPLIT+STEP_W)'(sd_s7.h);
			gp_s8 <= gp_s7;
			gm_s8 <= gm_s7;
			sd_s8 <= sd_s7;

			np_s9 <= (N_W'(ph_s8) << NH_SPLIT) + N_W'(pl_s8) + N_W'(sd_s8.a_mag);
			nm_s9 <= (N_W'(mh_s8) << NH_SPLIT) + N_W'(ml_s8) + N_W'(sd_s8.a_mag);
			gp_s9 <= gp_s8;
			gm_s9 <= gm_s8;
			sd_s9 <= sd_s8;
		end
	end

	assign nsel[0] = np_s9;
	assign nsel[1] = nm_s9;
	assign gsel[0] = gp_s9;
	assign gsel[1] = gm_s9;

	always_comb begin
		dv_d[0].side.x       = sd_s9.x;
		dv_d[0].side.dvs     = {sd_s9.a_mag, 1'b0};
		dv_d[0].side.status  = sd_s9.status;
		dv_d[0].side.disc_nz = sd_s9.disc_nz;
		for (int k = 0; k < 2; k++) begin
			dv_d[0].lane[k].ovf = (DIV_W'(nsel[k][N_W-1:Q_W]) >= {sd_s9.a_mag, 1'b0});
			dv_d[0].lane[k].rem = dv_d[0].lane[k].ovf ? '0 : DIV_W'(nsel[k][N_W-1:Q_W]);
			dv_d[0].lane[k].nq  = nsel[k][Q_W-1:0];
			dv_d[0].lane[k].neg = gsel[k];
		end
	end

	assign dv_v[0] = v_s9;

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		fde_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (dv_v[j]),
			.d_in   (dv_d[j]),
			.vld_q  (dv_v[j+1]),
			.d_q    (dv_d[j+1])
		);
	end

	always_comb begin
		res        = '0;
		res.status = dv_d[Q_W].side.status;
		if (dv_d[Q_W].side.status == ST_OK) begin
			res.point_plus   = place_pt(dv_d[Q_W].side.x, dv_d[Q_W].lane[0]);
			res.point_minus  = place_pt(dv_d[Q_W].side.x, dv_d[Q_W].lane[1]);
			res.minus_is_max = dv_d[Q_W].side.disc_nz;
		end
	end

	assign push         = en && dv_v[Q_W];
	assign result_valid = (cnt_q != 2'd0);
	assign pop          = result_valid && !result_stall;
	assign result       = buf0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (cnt_q == 2'd2)) begin
			buf0_q <= buf1_q;
		end else if (push && ((cnt_q == 2'd0) || pop)) begin
			buf0_q <= res;
		end
		if (push && (cnt_q == 2'd1) && !pop) begin
			buf1_q <= res;
		end
	end

endmodule

FILE: rtl/core/fde_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one root bit of the discriminant and passes the rest on.
// ----------------------------------------------------------------------------
module fde_sqrt_cell import fde_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  sq_t  d_in,
	output logic vld_q,
	output sq_t  d_q
);

	logic [REM_W+1:0] t;
	logic [REM_W+1:0] trial;
	logic             take;
	sq_t              nxt;

	always_comb begin
		t     = {d_in.rem, d_in.bits[DISC_W-1 -: 2]};
		trial = {{(REM_W-ROOT_W){1'b0}}, d_in.root, 2'b01};
		take  = (t >= trial);
		nxt.rem  = take ? REM_W'(t - trial) : REM_W'(t);
		nxt.root = {d_in.root[ROOT_W-2:0], take};
		nxt.bits = {d_in.bits[DISC_W-3:0], 2'b00};
		nxt.side = d_in.side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

endmodule

FILE: rtl/core/fde_div_cell.sv
// ----------------------------------------------------------------------------
// Division cell
// Resolves one quotient bit for both roots and passes the rest on.
// ----------------------------------------------------------------------------
module fde_div_cell import fde_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  dv_t  d_in,
	output logic vld_q,
	output dv_t  d_q
);

	logic [DIV_W:0] t    [2];
	logic           take [2];
	dv_t            nxt;

	always_comb begin
		nxt = d_in;
		for (int i = 0; i < 2; i++) begin
			t[i]    = {d_in.lane[i].rem, d_in.lane[i].nq[Q_W-1]};
			take[i] = (t[i] >= {1'b0, d_in.side.dvs});
			nxt.lane[i].rem = take[i] ? DIV_W'(t[i] - {1'b0, d_in.side.dvs})
				: DIV_W'(t[i]);
			nxt.lane[i].nq  = {d_in.lane[i].nq[Q_W-2:0], take[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

endmodule

FILE: rtl/core/fde_coef.sv
// ----------------------------------------------------------------------------
// Coefficient front end
// Forms the differences, the quadratic coefficients and the discriminant.
// ----------------------------------------------------------------------------
module fde_coef import fde_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vld_in,
	input  in_item_t  item,
	output logic      vld_q,
	output sq_t       d_q
);

	logic signed [DIFF_W-1:0] e0, e1, e2, e3;
	logic signed [DIFF_W-1:0] d1_s1, d2_s1, d3_s1;
	logic signed [DATA_W-1:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic        [STEP_W-1:0] h_s1, h_s2, h_s3, h_s4, h_s5;
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [B_W-1:0]    d1x, d2x, d3x, dd;
	logic signed [A_W-1:0]    a_s2;
	logic signed [B_W-1:0]    b_s2, b_s3, b_s4, b_s5;
	logic signed [C_W-1:0]    c_s2;
	logic                     z_s2, z_s3, z_s4, z_s5;

	logic                     an_s3, an_s4, an_s5, cn_s3, cn_s4, cn_s5;
	logic                     cz_s3, cz_s4, cz_s5;
	logic [AMAG_W-1:0]        am_s3, am_s4, am_s5;
	logic [BMAG_W-1:0]        bm_s3;
	logic [CMAG_W-1:0]        cm_s3;

	logic [BB_SPLIT+BMAG_W-1:0]          bbl_s4;
	logic [BMAG_W-BB_SPLIT+BMAG_W-1:0]   bbh_s4;
	logic [AC_SPLIT+CMAG_W-1:0]          acl_s4;
	logic [AMAG_W-AC_SPLIT+CMAG_W-1:0]   ach_s4;
	logic [DISC_W-1:0]                   bb_s5, ac_s5;

	logic              add;
	status_t           st;
	logic [DISC_W-1:0] disc;
	sq_side_t          side_s6;
	logic [DISC_W-1:0] disc_s6;

	assign e0  = DIFF_W'(item.sample0);
	assign e1  = DIFF_W'(item.sample1);
	assign e2  = DIFF_W'(item.sample2);
	assign e3  = DIFF_W'(item.sample3);
	assign d1x = B_W'(d1_s1);
	assign d2x = B_W'(d2_s1);
	assign d3x = B_W'(d3_s1);
	assign dd  = d2x - d3x;

	always_comb begin
		add = cz_s5 && (an_s5 != cn_s5);
		st  = ST_OK;
		if (z_s5) begin
			st = ST_ZERO_D3;
		end else if (!add && (bb_s5 < ac_s5)) begin
			st = ST_NEG_DISC;
		end
		disc = add ? (bb_s5 + ac_s5) : (bb_s5 - ac_s5);
		if (st != ST_OK) begin
			disc = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1 <= e1 - e0;
			d2_s1 <= e2 - (e1 <<< 1) + e0;
			d3_s1 <= e3 - ((e2 <<< 1) + e2) + ((e1 <<< 1) + e1) - e0;
			x_s1  <= item.x_start;
			h_s1  <= item.step;

			a_s2 <= A_W'((d3x <<< 1) + d3x);
			b_s2 <= (dd <<< 2) + (dd <<< 1);
			c_s2 <= C_W'((d1x <<< 2) + (d1x <<< 1) - ((d2x <<< 1) + d2x) + (d3x <<< 1));
			z_s2 <= (d3_s1 == '0);
			x_s2 <= x_s1;
			h_s2 <= h_s1;

			an_s3 <= a_s2[A_W-1];
			cn_s3 <= c_s2[C_W-1];
			cz_s3 <= (c_s2 != '0);
			am_s3 <= AMAG_W'(a_s2[A_W-1] ? -a_s2 : a_s2);
			bm_s3 <= BMAG_W'(b_s2[B_W-1] ? -b_s2 : b_s2);
			cm_s3 <= CMAG_W'(c_s2[C_W-1] ? -c_s2 : c_s2);
			b_s3  <= b_s2;
			z_s3  <= z_s2;
			x_s3  <= x_s2;
			h_s3  <= h_s2;

			bbl_s4 <= (BB_SPLIT+BMAG_W)'(bm_s3[BB_SPLIT-1:0])
				* (BB_SPLIT+BMAG_W)'(bm_s3);
			bbh_s4 <= (BMAG_W-BB_SPLIT+BMAG_W)'(bm_s3[BMAG_W-1:BB_SPLIT])
				* (BMAG_W-BB_SPLIT+BMAG_W)'(bm_s3);
			acl_s4 <= (AC_SPLIT+CMAG_W)'(am_s3[AC_SPLIT-1:0])
				* (AC_SPLIT+CMAG_W)'(cm_s3);
			ach_s4 <= (AMAG_W-AC_SPLIT+CMAG_W)'(am_s3[AMAG_W-1:AC_SPLIT])
				* (AMAG_W-AC_SPLIT+CMAG_W)'(cm_s3);
			an_s4  <= an_s3;
			cn_s4  <= cn_s3;
			cz_s4  <= cz_s3;
			am_s4  <= am_s3;
			b_s4   <= b_s3;
			z_s4   <= z_s3;
			x_s4   <= x_s3;
			h_s4   <= h_s3;

			bb_s5 <= (DISC_W'(bbh_s4) << BB_SPLIT) + DISC_W'(bbl_s4);
			ac_s5 <= ((DISC_W'(ach_s4) << AC_SPLIT) + DISC_W'(acl_s4)) << 2;
			an_s5 <= an_s4;
			cn_s5 <= cn_s4;
			cz_s5 <= cz_s4;
			am_s5 <= am_s4;
			b_s5  <= b_s4;
			z_s5  <= z_s4;
			x_s5  <= x_s4;
			h_s5  <= h_s4;

			disc_s6         <= disc;
			side_s6.x       <= x_s5;
			side_s6.h       <= h_s5;
			side_s6.b       <= b_s5;
			side_s6.a_neg   <= an_s5;
			side_s6.a_mag   <= am_s5;
			side_s6.status  <= st;
			side_s6.disc_nz <= (disc != '0);
		end
	end

	assign vld_q     = v_s6;
	assign d_q.rem   = '0;
	assign d_q.root  = '0;
	assign d_q.bits  = disc_s6;
	assign d_q.side  = side_s6;

endmodule
